>>> sv/les_pkg.sv
// Shared types and constants of the local extremum seed labeler.
package les_pkg;

  localparam int MAX_WIDTH_DEF   = 2048;
  localparam int MAX_HEIGHT_DEF  = 2048;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CFG_BITS   = 12;
  localparam int POS_BITS   = 11;
  localparam int LABEL_BITS = 22;
  localparam int NEIGHBOURS = 8;
  localparam int SIZE_MIN   = 3;

  localparam logic [LABEL_BITS-1:0] LABEL_MAX  = {LABEL_BITS{1'b1}};
  localparam logic [CFG_BITS-1:0]   SIZE_RESET = CFG_BITS'(2048);

  typedef enum logic [1:0] {
    REG_SEED_MODE    = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } cfg_reg_e;

  // Classification that the front end attaches to each item.
  typedef struct packed {
    logic win;         // a full 3x3 window is complete with this pixel
    logic frame_done;  // last pixel of the frame
  } les_tag_t;

endpackage

>>> sv/les_front.sv
// Front end: tracks the raster position and classifies each accepted pixel.
module les_front #(
  parameter int MAX_WIDTH   = les_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = les_pkg::MAX_HEIGHT_DEF,
  parameter int SAMPLE_BITS = les_pkg::SAMPLE_BITS_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [les_pkg::CFG_BITS-1:0]  frame_width_i,
  input  logic [les_pkg::CFG_BITS-1:0]  frame_height_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output logic signed [SAMPLE_BITS-1:0] push_sample_o,
  output logic [CW-1:0]                 push_col_o,
  output logic [RW-1:0]                 push_row_o,
  output les_pkg::les_tag_t             push_tag_o
);

  localparam int WW = (CW + 1 > les_pkg::CFG_BITS) ? CW + 1 : les_pkg::CFG_BITS;
  localparam int HW = (RW + 1 > les_pkg::CFG_BITS) ? RW + 1 : les_pkg::CFG_BITS;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [WW-1:0] width_raw, width_clamped, col_next;
  logic [HW-1:0] height_raw, height_clamped, row_next;
  logic          last_col, frame_done, accept;

  assign accept = in_valid_i && push_ready_i;

  // Sizes outside the legal range act as the nearest bound.
  always_comb begin
    width_raw  = WW'(frame_width_i);
    height_raw = HW'(frame_height_i);
    if (width_raw < WW'(les_pkg::SIZE_MIN)) begin
      width_clamped = WW'(les_pkg::SIZE_MIN);
    end else if (width_raw > WW'(MAX_WIDTH)) begin
      width_clamped = WW'(MAX_WIDTH);
    end else begin
      width_clamped = width_raw;
    end
    if (height_raw < HW'(les_pkg::SIZE_MIN)) begin
      height_clamped = HW'(les_pkg::SIZE_MIN);
    end else if (height_raw > HW'(MAX_HEIGHT)) begin
      height_clamped = HW'(MAX_HEIGHT);
    end else begin
      height_clamped = height_raw;
    end
    col_next   = WW'(col_q) + WW'(1);
    row_next   = HW'(row_q) + HW'(1);
    last_col   = (col_next >= width_clamped);
    frame_done = last_col && (row_next >= height_clamped);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (frame_done) begin
        col_d = '0;
        row_d = '0;
      end else if (last_col) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign in_ready_o    = push_ready_i;
  assign push_valid_o  = in_valid_i;
  assign push_sample_o = sample_i;
  assign push_col_o    = col_q;
  assign push_row_o    = row_q;
  assign push_tag_o.win        = (col_q > CW'(1)) && (row_q > RW'(1));
  assign push_tag_o.frame_done = frame_done;

endmodule

>>> sv/les_queue.sv
// Two-entry item queue between the front end and the back end.
module les_queue #(
  parameter int DW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  logic [DW-1:0] push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output logic [DW-1:0] pop_data_o
);

  logic [DW-1:0] ent_q [2];
  logic          wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = ent_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/les_back.sv
// Back end: line store, 3x3 window, extremum test, labeling and output register.
module les_back #(
  parameter int MAX_WIDTH   = les_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = les_pkg::MAX_HEIGHT_DEF,
  parameter int SAMPLE_BITS = les_pkg::SAMPLE_BITS_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               seed_mode_i,
  input  logic                               q_valid_i,
  output logic                               q_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]      q_sample_i,
  input  logic [CW-1:0]                      q_col_i,
  input  logic [RW-1:0]                      q_row_i,
  input  les_pkg::les_tag_t                  q_tag_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               is_seed_o,
  output logic [les_pkg::POS_BITS-1:0]       seed_column_o,
  output logic [les_pkg::POS_BITS-1:0]       seed_row_o,
  output logic [les_pkg::LABEL_BITS-1:0]     seed_label_o,
  output logic                               frame_end_o,
  output logic [les_pkg::LABEL_BITS-1:0]     total_seeds_o,
  output logic                               none_found_o
);

  localparam int SB      = SAMPLE_BITS;
  localparam int PosBits = les_pkg::POS_BITS;
  localparam int LB      = les_pkg::LABEL_BITS;

  // Each line store entry holds {row r-2, row r-1} of one column.
  logic [2*SB-1:0]        mem_q [MAX_WIDTH];
  logic [2*SB-1:0]        rd_q;

  logic                   s1_valid_q, s1_valid_d;
  logic signed [SB-1:0]   s1_sample_q;
  logic [CW-1:0]          s1_col_q;
  logic [RW-1:0]          s1_row_q;
  les_pkg::les_tag_t      s1_tag_q;

  logic signed [SB-1:0]   win_q [6];
  logic [LB-1:0]          cnt_q, cnt_d;

  logic                   out_valid_q;
  logic                   is_seed_q, frame_end_q, none_found_q;
  logic [PosBits-1:0]     col_out_q, row_out_q;
  logic [LB-1:0]          label_q, total_q;

  logic signed [SB-1:0]   top, mid;
  logic signed [SB-1:0]   nb [les_pkg::NEIGHBOURS];
  logic                   seed, has_result, s1_fire, pop;
  logic [LB-1:0]          label_next;

  assign top = rd_q[2*SB-1:SB];
  assign mid = rd_q[SB-1:0];

  always_comb begin
    nb[0] = win_q[0];
    nb[1] = win_q[1];
    nb[2] = win_q[2];
    nb[3] = win_q[3];
    nb[4] = win_q[5];
    nb[5] = top;
    nb[6] = mid;
    nb[7] = s1_sample_q;
  end

  // Eight independent compares against the window center.
  always_comb begin
    seed = s1_tag_q.win;
    for (int k = 0; k < les_pkg::NEIGHBOURS; k++) begin
      if (seed_mode_i) begin
        if (!(win_q[4] < nb[k])) seed = 1'b0;
      end else begin
        if (!(win_q[4] > nb[k])) seed = 1'b0;
      end
    end
  end

  always_comb begin
    if (seed && (cnt_q != les_pkg::LABEL_MAX)) begin
      label_next = cnt_q + LB'(1);
    end else begin
      label_next = cnt_q;
    end
  end

  assign has_result = seed || s1_tag_q.frame_done;
  assign s1_fire    = s1_valid_q && (!has_result || !out_valid_q || out_ready_i);
  assign pop        = q_valid_i && (!s1_valid_q || s1_fire);
  assign q_ready_o  = !s1_valid_q || s1_fire;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pop) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    cnt_d = cnt_q;
    if (s1_fire) begin
      cnt_d = s1_tag_q.frame_done ? '0 : label_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      s1_valid_q <= s1_valid_d;
      cnt_q      <= cnt_d;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_fire && has_result) begin
        out_valid_q <= 1'b1;
      end
      if (s1_fire) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= top;
        win_q[4] <= mid;
        win_q[5] <= s1_sample_q;
      end
    end
  end

  // Stage payload and result payload.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_sample_q <= q_sample_i;
      s1_col_q    <= q_col_i;
      s1_row_q    <= q_row_i;
      s1_tag_q    <= q_tag_i;
    end
    if (s1_fire && has_result) begin
      is_seed_q    <= seed;
      col_out_q    <= seed ? PosBits'(s1_col_q - CW'(1)) : '0;
      row_out_q    <= seed ? PosBits'(s1_row_q - RW'(1)) : '0;
      label_q      <= seed ? label_next : '0;
      frame_end_q  <= s1_tag_q.frame_done;
      total_q      <= s1_tag_q.frame_done ? label_next : '0;
      none_found_q <= s1_tag_q.frame_done && (label_next == '0);
    end
  end

  // The write of one pixel and the read for the next always hit different columns.
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      mem_q[s1_col_q] <= {mid, s1_sample_q};
    end
    if (pop) begin
      rd_q <= mem_q[q_col_i];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign is_seed_o     = is_seed_q;
  assign seed_column_o = col_out_q;
  assign seed_row_o    = row_out_q;
  assign seed_label_o  = label_q;
  assign frame_end_o   = frame_end_q;
  assign total_seeds_o = total_q;
  assign none_found_o  = none_found_q;

  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (is_seed_q || frame_end_q))
    else $error("result item carries neither a seed nor a frame end");

  a_none_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && none_found_q) |-> (frame_end_q && (total_q == '0)))
    else $error("none_found set without an empty frame end");

  a_label_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && is_seed_q) |-> (label_q != '0))
    else $error("seed reported with label zero");

  a_count_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_tag_q.frame_done) |=> (cnt_q == '0))
    else $error("seed counter not cleared after frame end");

endmodule

>>> sv/local_extremum_seed_labeler_core.sv
// Top level of the local extremum seed labeler.
//
// Pixels of one band enter on the in channel (in_valid_i / in_ready_o,
// sample_i) in raster order, one per clock at full rate. A pixel that
// completes a 3x3 window whose center is a strict local maximum (seed_mode 0)
// or minimum (seed_mode 1) yields a result item with the center's column, row
// and raster-order label; the last pixel of a frame also carries the frame's
// seed total and none_found. Pixels that cause no result produce no item.
// Registers are written on the cfg channel (cfg_valid_i / cfg_ready_o, index
// 0 seed_mode, 1 frame_width, 2 frame_height), which is always ready.
// A result passes through the queue, the back-end stage register and the
// output register. Throughput is one pixel per cycle while the back end
// does not stall, set by the line store with one read and one write each cycle.
// Reset clears the position, the window and the seed counter and sets the
// registers to their defaults; the line store needs no clearing.
// When the receiver stalls, the output register holds its item, pixels without
// a result keep flowing, and the next result-producing pixel stalls the back
// end; the two-entry queue then fills and in_ready_o falls.
module local_extremum_seed_labeler_core #(
  parameter int MAX_WIDTH   = les_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = les_pkg::MAX_HEIGHT_DEF,
  parameter int SAMPLE_BITS = les_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [les_pkg::CFG_BITS-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]  sample_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           is_seed_o,
  output logic [les_pkg::POS_BITS-1:0]   seed_column_o,
  output logic [les_pkg::POS_BITS-1:0]   seed_row_o,
  output logic [les_pkg::LABEL_BITS-1:0] seed_label_o,
  output logic                           frame_end_o,
  output logic [les_pkg::LABEL_BITS-1:0] total_seeds_o,
  output logic                           none_found_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int TW = $bits(les_pkg::les_tag_t);
  localparam int DW = SAMPLE_BITS + CW + RW + TW;

  logic                          seed_mode_q;
  logic [les_pkg::CFG_BITS-1:0]  frame_width_q, frame_height_q;

  logic                          push_valid, push_ready;
  logic signed [SAMPLE_BITS-1:0] push_sample;
  logic [CW-1:0]                 push_col;
  logic [RW-1:0]                 push_row;
  les_pkg::les_tag_t             push_tag;

  logic                          pop_valid, pop_ready;
  logic [DW-1:0]                 pop_data;
  logic signed [SAMPLE_BITS-1:0] pop_sample;
  logic [CW-1:0]                 pop_col;
  logic [RW-1:0]                 pop_row;
  les_pkg::les_tag_t             pop_tag;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_mode_q    <= 1'b0;
      frame_width_q  <= les_pkg::SIZE_RESET;
      frame_height_q <= les_pkg::SIZE_RESET;
    end else if (cfg_valid_i) begin
      case (les_pkg::cfg_reg_e'(cfg_index_i))
        les_pkg::REG_SEED_MODE:    seed_mode_q    <= cfg_data_i[0];
        les_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        les_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  les_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_sample_o  (push_sample),
    .push_col_o     (push_col),
    .push_row_o     (push_row),
    .push_tag_o     (push_tag)
  );

  les_queue #(
    .DW (DW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_sample, push_col, push_row, push_tag}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign {pop_sample, pop_col, pop_row, pop_tag} = pop_data;

  les_back #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .seed_mode_i   (seed_mode_q),
    .q_valid_i     (pop_valid),
    .q_ready_o     (pop_ready),
    .q_sample_i    (pop_sample),
    .q_col_i       (pop_col),
    .q_row_i       (pop_row),
    .q_tag_i       (pop_tag),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .is_seed_o     (is_seed_o),
    .seed_column_o (seed_column_o),
    .seed_row_o    (seed_row_o),
    .seed_label_o  (seed_label_o),
    .frame_end_o   (frame_end_o),
    .total_seeds_o (total_seeds_o),
    .none_found_o  (none_found_o)
  );

endmodule

>>> verif/tb_local_extremum_seed_labeler_core.sv
// Testbench for the local extremum seed labeler: random frames, predicted seeds, checked results.
`timescale 1ns / 1ps

module tb_local_extremum_seed_labeler_core;

  localparam int SW = les_pkg::SAMPLE_BITS_DEF;

  typedef struct packed {
    logic                           is_seed;
    logic [les_pkg::POS_BITS-1:0]   seed_column;
    logic [les_pkg::POS_BITS-1:0]   seed_row;
    logic [les_pkg::LABEL_BITS-1:0] seed_label;
    logic                           frame_end;
    logic [les_pkg::LABEL_BITS-1:0] total_seeds;
    logic                           none_found;
  } seed_report_t;

  typedef enum int {
    FILL_WIDE,
    FILL_NARROW,
    FILL_EXTREME
  } fill_e;

  // Tracks the 3x3 window state of the labeler and the seed reports it owes.
  class seed_report_tracker;
    logic signed [SW-1:0]           upper_line[les_pkg::MAX_WIDTH_DEF];
    logic signed [SW-1:0]           middle_line[les_pkg::MAX_WIDTH_DEF];
    logic signed [SW-1:0]           window[6];
    int                             col;
    int                             row;
    logic [les_pkg::LABEL_BITS-1:0] found;
    bit                             pit_mode;
    logic [les_pkg::CFG_BITS-1:0]   width_reg;
    logic [les_pkg::CFG_BITS-1:0]   height_reg;
    seed_report_t                   awaited[$];
    int                             fault_count;

    function new();
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      col         = 0;
      row         = 0;
      found       = '0;
      pit_mode    = 1'b0;
      width_reg   = les_pkg::SIZE_RESET;
      height_reg  = les_pkg::SIZE_RESET;
      fault_count = 0;
    endfunction

    function void set_register(les_pkg::cfg_reg_e idx, logic [les_pkg::CFG_BITS-1:0] data);
      case (idx)
        les_pkg::REG_SEED_MODE:    pit_mode = data[0];
        les_pkg::REG_FRAME_WIDTH:  width_reg = data;
        les_pkg::REG_FRAME_HEIGHT: height_reg = data;
        default: ;
      endcase
    endfunction

    function int clamp(logic [les_pkg::CFG_BITS-1:0] v, int hi);
      if (int'(v) < les_pkg::SIZE_MIN) return les_pkg::SIZE_MIN;
      if (int'(v) > hi) return hi;
      return int'(v);
    endfunction

    function int frame_pixels();
      return clamp(width_reg, les_pkg::MAX_WIDTH_DEF) *
             clamp(height_reg, les_pkg::MAX_HEIGHT_DEF);
    endfunction

    function void take_pixel(logic signed [SW-1:0] bot);
      int                   w;
      int                   h;
      int                   ci;
      logic signed [SW-1:0] top;
      logic signed [SW-1:0] mid;
      logic signed [SW-1:0] ctr;
      logic signed [SW-1:0] ring[les_pkg::NEIGHBOURS];
      bit                   seed;
      bit                   last_col;
      bit                   done;
      seed_report_t         rep;
      w        = clamp(width_reg, les_pkg::MAX_WIDTH_DEF);
      h        = clamp(height_reg, les_pkg::MAX_HEIGHT_DEF);
      ci       = (col < les_pkg::MAX_WIDTH_DEF) ? col : les_pkg::MAX_WIDTH_DEF - 1;
      top      = upper_line[ci];
      mid      = middle_line[ci];
      last_col = (col + 1 >= w);
      done     = last_col && (row + 1 >= h);
      seed     = 1'b0;
      rep      = '0;
      if (row >= 2 && col >= 2) begin
        ctr  = window[4];
        ring = '{window[0], window[1], window[2], window[3], window[5], top, mid, bot};
        seed = 1'b1;
        for (int k = 0; k < les_pkg::NEIGHBOURS; k++) begin
          if (pit_mode ? !(ctr < ring[k]) : !(ctr > ring[k])) seed = 1'b0;
        end
      end
      if (seed) begin
        if (found != les_pkg::LABEL_MAX) found = found + 1'b1;
        rep.is_seed     = 1'b1;
        rep.seed_column = les_pkg::POS_BITS'(col - 1);
        rep.seed_row    = les_pkg::POS_BITS'(row - 1);
        rep.seed_label  = found;
      end
      upper_line[ci]  = mid;
      middle_line[ci] = bot;
      window[0] = window[3];
      window[1] = window[4];
      window[2] = window[5];
      window[3] = top;
      window[4] = mid;
      window[5] = bot;
      if (done) begin
        rep.frame_end   = 1'b1;
        rep.total_seeds = found;
        rep.none_found  = (found == '0);
        found = '0;
        col   = 0;
        row   = 0;
      end else if (last_col) begin
        col = 0;
        row = (row + 1) % (1 << les_pkg::POS_BITS);
      end else begin
        col = (col + 1) % (1 << les_pkg::POS_BITS);
      end
      if (seed || done) awaited.push_back(rep);
    endfunction

    function void compare_field(string name, logic [les_pkg::LABEL_BITS-1:0] want,
                                logic [les_pkg::LABEL_BITS-1:0] got);
      if (got !== want) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
      end
    endfunction

    function void match_report(seed_report_t got);
      seed_report_t want;
      if (awaited.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: result with nothing awaited: seed %0b col %0d row %0d end %0b",
                   $realtime, got.is_seed, got.seed_column, got.seed_row, got.frame_end);
        return;
      end
      want = awaited.pop_front();
      compare_field("is_seed", want.is_seed, got.is_seed);
      compare_field("seed_column", want.seed_column, got.seed_column);
      compare_field("seed_row", want.seed_row, got.seed_row);
      compare_field("seed_label", want.seed_label, got.seed_label);
      compare_field("frame_end", want.frame_end, got.frame_end);
      compare_field("total_seeds", want.total_seeds, got.total_seeds);
      compare_field("none_found", want.none_found, got.none_found);
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_valid;
  logic                           cfg_ready_o;
  les_pkg::cfg_reg_e              cfg_index;
  logic [les_pkg::CFG_BITS-1:0]   cfg_data;
  logic                           in_valid;
  logic                           in_ready_o;
  logic signed [SW-1:0]           pixel;
  logic                           out_valid_o;
  logic                           out_ready;
  logic                           is_seed_o;
  logic [les_pkg::POS_BITS-1:0]   seed_column_o;
  logic [les_pkg::POS_BITS-1:0]   seed_row_o;
  logic [les_pkg::LABEL_BITS-1:0] seed_label_o;
  logic                           frame_end_o;
  logic [les_pkg::LABEL_BITS-1:0] total_seeds_o;
  logic                           none_found_o;

  seed_report_tracker sb;
  bit tx_calm;
  bit rx_calm;
  int hold_request;

  local_extremum_seed_labeler_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .sample_i      (pixel),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .is_seed_o     (is_seed_o),
    .seed_column_o (seed_column_o),
    .seed_row_o    (seed_row_o),
    .seed_label_o  (seed_label_o),
    .frame_end_o   (frame_end_o),
    .total_seeds_o (total_seeds_o),
    .none_found_o  (none_found_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Inputs are noted before outputs are checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) sb.take_pixel(pixel);
      if (out_valid_o && out_ready)
        sb.match_report('{is_seed_o, seed_column_o, seed_row_o, seed_label_o,
                          frame_end_o, total_seeds_o, none_found_o});
    end
  end

  function automatic int idle_cycles(bit calm);
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic logic signed [SW-1:0] next_sample(fill_e style);
    case (style)
      FILL_WIDE:   return SW'($urandom);
      FILL_NARROW: return SW'($urandom_range(0, 3) - 2);
      default: begin
        case ($urandom_range(0, 2))
          0:       return {1'b0, {(SW-1){1'b1}}};
          1:       return {1'b1, {(SW-1){1'b0}}};
          default: return SW'($urandom);
        endcase
      end
    endcase
  endfunction

  // Receiver: random stalls per item, plus a long hold-off when one is requested.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        out_ready <= 1'b0;
        repeat (hold_request) @(negedge clk_i);
        hold_request = 0;
      end else begin
        stall = idle_cycles(rx_calm);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready));
    end
  end

  // All driver tasks start and end at a falling edge.
  task automatic send_pixel(logic signed [SW-1:0] value);
    int gap;
    gap = idle_cycles(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    pixel    <= value;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic write_reg(les_pkg::cfg_reg_e idx, logic [les_pkg::CFG_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(idx, data);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Stop offering pixels and let every owed result drain before a register write.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // A 3x3 frame whose center is center_val and whose other pixels are rest_val;
  // with tie set, the last pixel equals the center so no seed may be reported.
  task automatic send_spike(logic signed [SW-1:0] center_val,
                            logic signed [SW-1:0] rest_val, bit tie);
    for (int i = 0; i < 9; i++) begin
      if (i == 4 || (tie && i == 8)) send_pixel(center_val);
      else send_pixel(rest_val);
    end
  endtask

  task automatic send_frame(fill_e style);
    int n;
    n = sb.frame_pixels();
    repeat (n) send_pixel(next_sample(style));
  endtask

  initial begin
    int    random_sent;
    int    frames;
    fill_e style;
    sb           = new();
    rst_ni       = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = les_pkg::REG_SEED_MODE;
    cfg_data     = '0;
    in_valid     = 1'b0;
    pixel        = '0;
    tx_calm      = 1'b0;
    rx_calm      = 1'b0;
    hold_request = 0;
    random_sent  = 0;
    frames       = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: a clean peak, a peak tied with a neighbor, then a clean pit
    // on a frame whose size registers lie below the minimum.
    write_reg(les_pkg::REG_FRAME_WIDTH, les_pkg::CFG_BITS'(3));
    write_reg(les_pkg::REG_FRAME_HEIGHT, les_pkg::CFG_BITS'(3));
    write_reg(les_pkg::REG_SEED_MODE, les_pkg::CFG_BITS'(0));
    send_spike(16'sh7FFF, 16'sh8000, 1'b0);
    send_spike(16'sh7FFF, 16'sh8000, 1'b1);
    settle();
    write_reg(les_pkg::REG_SEED_MODE, les_pkg::CFG_BITS'(1));
    write_reg(les_pkg::REG_FRAME_WIDTH, les_pkg::CFG_BITS'(1));
    write_reg(les_pkg::REG_FRAME_HEIGHT, les_pkg::CFG_BITS'(2));
    send_spike(16'sh8000, 16'sh7FFF, 1'b0);

    while (random_sent < 1080) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      style   = fill_e'($urandom_range(0, 2));
      if (frames == 4) begin
        // A wide frame with a long receiver hold-off so the block backs up.
        settle();
        write_reg(les_pkg::REG_FRAME_WIDTH, les_pkg::CFG_BITS'(40));
        write_reg(les_pkg::REG_FRAME_HEIGHT, les_pkg::CFG_BITS'(12));
        style        = FILL_WIDE;
        hold_request = 400;
      end else if (frames == 0 || $urandom_range(0, 1) == 1) begin
        settle();
        write_reg(les_pkg::REG_SEED_MODE, les_pkg::CFG_BITS'($urandom));
        write_reg(les_pkg::REG_FRAME_WIDTH, ($urandom_range(0, 7) == 0) ?
                  les_pkg::CFG_BITS'($urandom_range(0, 2)) :
                  les_pkg::CFG_BITS'($urandom_range(3, 12)));
        write_reg(les_pkg::REG_FRAME_HEIGHT, ($urandom_range(0, 7) == 0) ?
                  les_pkg::CFG_BITS'($urandom_range(0, 2)) :
                  les_pkg::CFG_BITS'($urandom_range(3, 9)));
      end
      random_sent += sb.frame_pixels();
      send_frame(style);
      frames++;
    end

    // Sizes above the maximum, each cut short by a size change mid-frame:
    // first a row clamped to the widest width, then a frame clamped to the tallest.
    settle();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    write_reg(les_pkg::REG_SEED_MODE, les_pkg::CFG_BITS'($urandom));
    write_reg(les_pkg::REG_FRAME_WIDTH, {les_pkg::CFG_BITS{1'b1}});
    write_reg(les_pkg::REG_FRAME_HEIGHT, les_pkg::CFG_BITS'(0));
    repeat (11) send_pixel(next_sample(FILL_WIDE));
    settle();
    write_reg(les_pkg::REG_FRAME_WIDTH, les_pkg::CFG_BITS'(3));
    repeat (7) send_pixel(next_sample(FILL_WIDE));
    settle();
    write_reg(les_pkg::REG_SEED_MODE, les_pkg::CFG_BITS'($urandom));
    write_reg(les_pkg::REG_FRAME_WIDTH, les_pkg::CFG_BITS'(1));
    write_reg(les_pkg::REG_FRAME_HEIGHT, {les_pkg::CFG_BITS{1'b1}});
    repeat (24) send_pixel(next_sample(FILL_NARROW));
    settle();
    write_reg(les_pkg::REG_FRAME_HEIGHT, les_pkg::CFG_BITS'(3));
    repeat (3) send_pixel(next_sample(FILL_NARROW));

    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (sb.fault_count == 0 && sb.awaited.size() == 0) begin
      $display("tb_local_extremum_seed_labeler_core: clean");
    end else begin
      $display("tb_local_extremum_seed_labeler_core: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_local_extremum_seed_labeler_core: errors");
    $finish;
  end

endmodule

>>> local_extremum_seed_labeler_core.f
sv/les_pkg.sv
sv/les_front.sv
sv/les_queue.sv
sv/les_back.sv
sv/local_extremum_seed_labeler_core.sv
verif/tb_local_extremum_seed_labeler_core.sv
